// ----- sv/assert_macros.svh -----
// Assertion shorthands for the stopwatch checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SWT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swt: assertion failed");

// Next-cycle implication.
`define SWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swt: assertion failed");

`endif

// ----- sv/swt_pkg.sv -----
package swt_pkg;

   localparam int SLOT_COUNT_DEF       = 10;
   localparam int TICKS_PER_SECOND_DEF = 512;

   localparam int SLOT_W    = 4;
   localparam int HOURS_W   = 7;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;
   localparam int HUND_W    = 7;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_UP  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_STEP = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  FAST_STEP_RST = 6'd5;

   typedef logic [3:0] action_type;

   localparam action_type ACT_TICK   = 4'd0;
   localparam action_type ACT_START  = 4'd1;
   localparam action_type ACT_PAUSE  = 4'd2;
   localparam action_type ACT_RESUME = 4'd3;
   localparam action_type ACT_CLEAR  = 4'd4;
   localparam action_type ACT_SET    = 4'd5;
   localparam action_type ACT_ADJUST = 4'd6;
   localparam action_type ACT_SAVE   = 4'd7;
   localparam action_type ACT_READ   = 4'd8;

   localparam logic [1:0] SEL_HOURS   = 2'd0;
   localparam logic [1:0] SEL_MINUTES = 2'd1;
   localparam logic [1:0] SEL_SECONDS = 2'd2;

   typedef struct packed {
      action_type  action;
      logic [7:0]  set_hours;
      logic [7:0]  set_minutes;
      logic [7:0]  set_seconds;
      logic [1:0]  field_select;
      logic        step_down;
      logic        fast;
      logic [7:0]  slot_number;
   } req_word_type;

   typedef struct packed {
      logic [HOURS_W-1:0]   hours;
      logic [MINUTES_W-1:0] minutes;
      logic [SECONDS_W-1:0] seconds;
      logic [HUND_W-1:0]    hundredths;
      logic                 countdown_done;
      logic [SLOT_W-1:0]    last_lap_slot;
      logic                 running;
   } rsp_word_type;

   typedef struct packed {
      logic              clear;
      logic              write;
      logic [SLOT_W-1:0] wr_slot;
      logic [SLOT_W-1:0] rd_slot;
   } lap_cmd_type;

endpackage

// ----- sv/swt_lap_store.sv -----
module swt_lap_store import swt_pkg::*; #(
   parameter int DEPTH  = SLOT_COUNT_DEF - 1,
   parameter int DATA_W = HOURS_W + MINUTES_W + SECONDS_W + $clog2(TICKS_PER_SECOND_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  lap_cmd_type       cmd,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;

   // slots are numbered from one
   assign wr_idx = IDX_W'(cmd.wr_slot - 1'b1);
   assign rd_idx = IDX_W'(cmd.rd_slot - 1'b1);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.write) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         entry_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = valid_ff[rd_idx] ? entry_ff[rd_idx] : '0;

endmodule

// ----- sv/stopwatch_countdown_lap_timer.sv -----
// Channel   Ports                          Handshake
// ------    -----------------------------  ------------------------
// request   req_valid req_ready req_word   valid/ready, one word
// response  rsp_valid rsp_ready rsp_word   valid/ready, one word
// config    csr_write_en csr_index csr_wdata  write on enable, no wait
//
// One word per cycle sustained while the response side is ready; each word passes
// through the input register, then one pass of counter/adjust logic and the
// hundredths multiply into the response register.
// Synchronous reset; the lap store's valid bits clear at once, no sweep.
// A stalled response holds the logic stage; the input register then takes a word
// only while empty and takes no more until that stage drains.
module stopwatch_countdown_lap_timer import swt_pkg::*; #(
   parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_word,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FRAC_W    = $clog2(TICKS_PER_SECOND);
   localparam int LAP_DEPTH = SLOT_COUNT - 1;
   localparam int LAP_W     = HOURS_W + MINUTES_W + SECONDS_W + FRAC_W;

   localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(TICKS_PER_SECOND - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LAP_DEPTH);

   // hundredths = floor(frac * 100 / TICKS_PER_SECOND) via reciprocal
   localparam int HUND_SHIFT = FRAC_W + $clog2(TICKS_PER_SECOND) + 1;
   localparam longint HUND_MULT =
      (100 * (longint'(1) << HUND_SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
   localparam int MULT_W = $clog2(HUND_MULT + 1);
   localparam int PROD_W = FRAC_W + MULT_W;

   typedef logic [SLOT_W-1:0] slot_table_type [256];

   function automatic slot_table_type build_slot_table();
      slot_table_type    t;
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         t[i] = r;
         r = (r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : SLOT_W'(r + 1'b1);
      end
      return t;
   endfunction

   localparam slot_table_type SLOT_MOD = build_slot_table();

   function automatic logic [HOURS_W-1:0] mod100(input logic [7:0] v);
      if (v >= 8'd200) begin
         return HOURS_W'(v - 8'd200);
      end else if (v >= 8'd100) begin
         return HOURS_W'(v - 8'd100);
      end
      return HOURS_W'(v);
   endfunction

   function automatic logic [MINUTES_W-1:0] mod60(input logic [7:0] v);
      if (v >= 8'd240) begin
         return MINUTES_W'(v - 8'd240);
      end else if (v >= 8'd180) begin
         return MINUTES_W'(v - 8'd180);
      end else if (v >= 8'd120) begin
         return MINUTES_W'(v - 8'd120);
      end else if (v >= 8'd60) begin
         return MINUTES_W'(v - 8'd60);
      end
      return MINUTES_W'(v);
   endfunction

   // modular step of a field already in range
   function automatic logic [6:0] step_field(input logic [6:0] v, input logic [6:0] modulus,
                                             input logic [5:0] amount, input logic down);
      logic [7:0] a;
      logic [7:0] m;
      logic [7:0] x;
      m = {1'b0, modulus};
      x = {1'b0, v};
      a = ({2'b00, amount} >= m) ? ({2'b00, amount} - m) : {2'b00, amount};
      if (down) begin
         return (x >= a) ? 7'(x - a) : 7'(x + m - a);
      end
      x = x + a;
      return (x >= m) ? 7'(x - m) : x[6:0];
   endfunction

   logic                   in_valid_ff;
   logic                   in_valid_in;
   req_word_type           in_word_ff;
   logic                   advance;

   logic                   count_up_ff;
   logic [CSR_DATA_W-1:0]  fast_step_ff;

   logic [HOURS_W-1:0]     hours_ff,   hours_in;
   logic [MINUTES_W-1:0]   minutes_ff, minutes_in;
   logic [SECONDS_W-1:0]   seconds_ff, seconds_in;
   logic [FRAC_W-1:0]      frac_ff,    frac_in;
   logic [SLOT_W-1:0]      next_slot_ff, next_slot_in;
   logic [SLOT_W-1:0]      saved_slot_ff, saved_slot_in;
   logic                   started_ff, started_in;
   logic                   halted_ff,  halted_in;
   logic                   done;

   lap_cmd_type            lap_cmd;
   logic [LAP_W-1:0]       lap_rd_data;
   logic [SLOT_W-1:0]      save_slot;
   logic [SLOT_W-1:0]      read_slot;
   logic [5:0]             amount;

   logic [HOURS_W-1:0]     shown_hours;
   logic [MINUTES_W-1:0]   shown_minutes;
   logic [SECONDS_W-1:0]   shown_seconds;
   logic [FRAC_W-1:0]      shown_frac;
   logic [PROD_W-1:0]      hund_prod;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_word_type           rsp_word_ff;
   rsp_word_type           rsp_word_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_up_ff  <= 1'b0;
         fast_step_ff <= FAST_STEP_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_COUNT_UP: begin
               count_up_ff <= csr_wdata[0];
            end
            CSR_FAST_STEP: begin
               fast_step_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign save_slot = (next_slot_ff == '0 || next_slot_ff > LAST_SLOT) ? SLOT_W'(1)
                                                                        : next_slot_ff;
   assign read_slot = SLOT_MOD[in_word_ff.slot_number];
   assign amount    = in_word_ff.fast ? fast_step_ff : 6'd1;

   always_comb begin
      hours_in      = hours_ff;
      minutes_in    = minutes_ff;
      seconds_in    = seconds_ff;
      frac_in       = frac_ff;
      next_slot_in  = next_slot_ff;
      saved_slot_in = saved_slot_ff;
      started_in    = started_ff;
      halted_in     = halted_ff;
      done          = 1'b0;
      lap_cmd       = '{clear: 1'b0, write: 1'b0, wr_slot: save_slot, rd_slot: read_slot};

      unique case (in_word_ff.action)
         ACT_TICK: begin
            if (started_ff && count_up_ff) begin
               frac_in = (frac_ff == FRAC_MAX) ? '0 : FRAC_W'(frac_ff + 1'b1);
               if (frac_ff == FRAC_MAX) begin
                  seconds_in = (seconds_ff == 6'd59) ? '0 : SECONDS_W'(seconds_ff + 1'b1);
                  if (seconds_ff == 6'd59) begin
                     minutes_in = (minutes_ff == 6'd59) ? '0 : MINUTES_W'(minutes_ff + 1'b1);
                     if (minutes_ff == 6'd59) begin
                        hours_in = (hours_ff == 7'd99) ? '0 : HOURS_W'(hours_ff + 1'b1);
                     end
                  end
               end
            end else if (started_ff && !halted_ff) begin
               if (frac_ff == '0 && seconds_ff == '0 && minutes_ff == '0 && hours_ff == '0) begin
                  halted_in = 1'b1;
                  done      = 1'b1;
               end else if (frac_ff != '0) begin
                  frac_in = FRAC_W'(frac_ff - 1'b1);
               end else begin
                  frac_in = FRAC_MAX;
                  if (seconds_ff != '0) begin
                     seconds_in = SECONDS_W'(seconds_ff - 1'b1);
                  end else begin
                     seconds_in = 6'd59;
                     if (minutes_ff != '0) begin
                        minutes_in = MINUTES_W'(minutes_ff - 1'b1);
                     end else begin
                        minutes_in = 6'd59;
                        hours_in   = HOURS_W'(hours_ff - 1'b1);
                     end
                  end
               end
            end
         end
         ACT_START: begin
            halted_in  = 1'b0;
            started_in = 1'b1;
         end
         ACT_PAUSE: begin
            started_in = 1'b0;
         end
         ACT_RESUME: begin
            started_in = 1'b1;
         end
         ACT_CLEAR: begin
            hours_in      = '0;
            minutes_in    = '0;
            seconds_in    = '0;
            frac_in       = '0;
            halted_in     = 1'b1;
            started_in    = 1'b0;
            next_slot_in  = SLOT_W'(1);
            saved_slot_in = '0;
            lap_cmd.clear = 1'b1;
         end
         ACT_SET: begin
            hours_in   = mod100(in_word_ff.set_hours);
            minutes_in = mod60(in_word_ff.set_minutes);
            seconds_in = mod60(in_word_ff.set_seconds);
            frac_in    = '0;
         end
         ACT_ADJUST: begin
            unique case (in_word_ff.field_select)
               SEL_HOURS: begin
                  hours_in = step_field(hours_ff, 7'd100, amount, in_word_ff.step_down);
               end
               SEL_MINUTES: begin
                  minutes_in = MINUTES_W'(step_field({1'b0, minutes_ff}, 7'd60, amount,
                                                     in_word_ff.step_down));
               end
               SEL_SECONDS: begin
                  seconds_in = SECONDS_W'(step_field({1'b0, seconds_ff}, 7'd60, amount,
                                                     in_word_ff.step_down));
               end
               default: begin
               end
            endcase
         end
         ACT_SAVE: begin
            saved_slot_in = save_slot;
            next_slot_in  = (save_slot == LAST_SLOT) ? SLOT_W'(1) : SLOT_W'(save_slot + 1'b1);
            lap_cmd.write = 1'b1;
         end
         default: begin
         end
      endcase

      if (!advance) begin
         lap_cmd.clear = 1'b0;
         lap_cmd.write = 1'b0;
      end
   end

   swt_lap_store #(
      .DEPTH  (LAP_DEPTH),
      .DATA_W (LAP_W)
   ) u_lap_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (lap_cmd),
      .wr_data ({hours_ff, minutes_ff, seconds_ff, frac_ff}),
      .rd_data (lap_rd_data)
   );

   always_comb begin
      if (in_word_ff.action == ACT_READ && read_slot != '0) begin
         {shown_hours, shown_minutes, shown_seconds, shown_frac} = lap_rd_data;
      end else begin
         shown_hours   = hours_in;
         shown_minutes = minutes_in;
         shown_seconds = seconds_in;
         shown_frac    = frac_in;
      end
   end

   assign hund_prod = PROD_W'(shown_frac) * PROD_W'(HUND_MULT);

   always_comb begin
      rsp_word_in.hours          = shown_hours;
      rsp_word_in.minutes        = shown_minutes;
      rsp_word_in.seconds        = shown_seconds;
      rsp_word_in.hundredths     = HUND_W'(hund_prod >> HUND_SHIFT);
      rsp_word_in.countdown_done = done;
      rsp_word_in.last_lap_slot  = saved_slot_in;
      rsp_word_in.running        = started_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff      <= '0;
         minutes_ff    <= '0;
         seconds_ff    <= '0;
         frac_ff       <= '0;
         next_slot_ff  <= SLOT_W'(1);
         saved_slot_ff <= '0;
         started_ff    <= 1'b0;
         halted_ff     <= 1'b1;
      end else if (advance) begin
         hours_ff      <= hours_in;
         minutes_ff    <= minutes_in;
         seconds_ff    <= seconds_in;
         frac_ff       <= frac_in;
         next_slot_ff  <= next_slot_in;
         saved_slot_ff <= saved_slot_in;
         started_ff    <= started_in;
         halted_ff     <= halted_in;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- sv/swt_checker.sv -----
`include "assert_macros.svh"

module swt_checker import swt_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   `SWT_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid, rsp_word.hours < 7'd100 && rsp_word.minutes < 6'd60 && rsp_word.seconds < 6'd60 && rsp_word.hundredths < 7'd100)

   `SWT_ASSERT_NOW(a_done_at_zero, clock, reset, rsp_valid && rsp_word.countdown_done, rsp_word.hours == '0 && rsp_word.minutes == '0 && rsp_word.seconds == '0 && rsp_word.hundredths == '0 && rsp_word.running)

   `SWT_ASSERT_NOW(a_rsp_latency, clock, reset, req_valid && req_ready, ##2 rsp_valid)

   `SWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind stopwatch_countdown_lap_timer swt_checker u_swt_checker (.*);

// ----- verif/stopwatch_countdown_lap_timer_tb.sv -----
module stopwatch_countdown_lap_timer_tb import swt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = SLOT_COUNT_DEF;
   localparam int TICKS       = TICKS_PER_SECOND_DEF;
   localparam int IDLE_PCT    = 19;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE      = 6;

   localparam action_type ACT_SPARE_LO = 4'd9;
   localparam action_type ACT_SPARE_HI = 4'd15;
   localparam logic [1:0] SEL_NONE     = 2'd3;

   typedef struct packed {
      logic [HOURS_W-1:0]   h;
      logic [MINUTES_W-1:0] m;
      logic [SECONDS_W-1:0] s;
      logic [8:0]           f;
   } stamp_type;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_word_type           req_word     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // timer state as the block should hold it
   stamp_type      cur_stamp         = '0;
   stamp_type      lap_stamps [1:SLOTS-1] = '{default: '0};
   int             next_lap          = 1;
   int             last_saved        = 0;
   bit             timer_running     = 1'b0;
   bit             countdown_stopped = 1'b1;
   bit             count_up_reg      = 1'b0;
   logic [5:0]     fast_step_reg     = FAST_STEP_RST;

   req_word_type   pending_words [$];
   rsp_word_type   timer_results [$];
   rsp_word_type   expected_word;

   bit steady       = 1'b0;
   int hold_left    = 0;
   int drained      = 0;
   int mismatches   = 0;
   int results_seen = 0;
   int words_sent   = 0;
   int ticks_sent   = 0;
   int expiries     = 0;
   int laps_saved   = 0;
   int slot_reads   = 0;
   int settings     = 1;

   always #2 clock = ~clock;

   stopwatch_countdown_lap_timer i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   function automatic int wrap_step(int v, int modulus, int amount, bit down);
      int a;
      a = amount % modulus;
      v = v % modulus;
      if (down) return (v + modulus - a) % modulus;
      return (v + a) % modulus;
   endfunction

   function automatic bit tick_timer();
      if (!timer_running) return 1'b0;
      if (count_up_reg) begin
         cur_stamp.f = 9'((cur_stamp.f + 1) % TICKS);
         if (cur_stamp.f == 0) begin
            cur_stamp.s = 6'((cur_stamp.s + 1) % 60);
            if (cur_stamp.s == 0) begin
               cur_stamp.m = 6'((cur_stamp.m + 1) % 60);
               if (cur_stamp.m == 0) cur_stamp.h = 7'((cur_stamp.h + 1) % 100);
            end
         end
         return 1'b0;
      end
      if (countdown_stopped) return 1'b0;
      if (cur_stamp == '0) begin
         countdown_stopped = 1'b1;
         return 1'b1;
      end
      if (cur_stamp.f != 0) begin
         cur_stamp.f--;
         return 1'b0;
      end
      cur_stamp.f = 9'(TICKS - 1);
      if (cur_stamp.s != 0) begin
         cur_stamp.s--;
         return 1'b0;
      end
      cur_stamp.s = 6'd59;
      if (cur_stamp.m != 0) begin
         cur_stamp.m--;
         return 1'b0;
      end
      cur_stamp.m = 6'd59;
      if (cur_stamp.h != 0) cur_stamp.h--;
      return 1'b0;
   endfunction

   function automatic rsp_word_type advance_timer(req_word_type w);
      rsp_word_type r;
      stamp_type    shown;
      bit           done;
      int           amount;
      int           k;
      done = 1'b0;
      case (w.action)
         ACT_TICK: begin
            done = tick_timer();
            ticks_sent++;
            if (done) expiries++;
         end
         ACT_START: begin
            countdown_stopped = 1'b0;
            timer_running = 1'b1;
         end
         ACT_PAUSE: timer_running = 1'b0;
         ACT_RESUME: timer_running = 1'b1;
         ACT_CLEAR: begin
            cur_stamp = '0;
            lap_stamps = '{default: '0};
            countdown_stopped = 1'b1;
            timer_running = 1'b0;
            next_lap = 1;
            last_saved = 0;
         end
         ACT_SET: begin
            cur_stamp.h = 7'(w.set_hours % 100);
            cur_stamp.m = 6'(w.set_minutes % 60);
            cur_stamp.s = 6'(w.set_seconds % 60);
            cur_stamp.f = '0;
         end
         ACT_ADJUST: begin
            amount = w.fast ? int'(fast_step_reg) : 1;
            case (w.field_select)
               SEL_HOURS: begin
                  cur_stamp.h = 7'(wrap_step(int'(cur_stamp.h), 100, amount, w.step_down));
               end
               SEL_MINUTES: begin
                  cur_stamp.m = 6'(wrap_step(int'(cur_stamp.m), 60, amount, w.step_down));
               end
               SEL_SECONDS: begin
                  cur_stamp.s = 6'(wrap_step(int'(cur_stamp.s), 60, amount, w.step_down));
               end
               default: ;
            endcase
         end
         ACT_SAVE: begin
            if (next_lap < 1 || next_lap > SLOTS - 1) next_lap = 1;
            last_saved = next_lap;
            lap_stamps[next_lap] = cur_stamp;
            next_lap = (next_lap % (SLOTS - 1)) + 1;
            laps_saved++;
         end
         default: ;
      endcase
      shown = cur_stamp;
      if (w.action == ACT_READ) begin
         k = int'(w.slot_number) % SLOTS;
         if (k != 0) shown = lap_stamps[k];
         slot_reads++;
      end
      r.hours          = shown.h;
      r.minutes        = shown.m;
      r.seconds        = shown.s;
      r.hundredths     = 7'((int'(shown.f) * 100) / TICKS);
      r.countdown_done = done;
      r.last_lap_slot  = 4'(last_saved);
      r.running        = timer_running;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            timer_results.push_back(advance_timer(req_word));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_word  <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // receiver hold-off, long enough to back the block up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            drained++;
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (rsp_valid && rsp_ready && (drained == 300 || drained == 1000)) begin
            hold_left <= HOLD_CYCLES;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (timer_results.size() == 0) begin
               $error("response word with nothing outstanding");
               mismatches++;
            end else begin
               expected_word = timer_results.pop_front();
               compare_field("hours", 32'(expected_word.hours), 32'(rsp_word.hours));
               compare_field("minutes", 32'(expected_word.minutes), 32'(rsp_word.minutes));
               compare_field("seconds", 32'(expected_word.seconds), 32'(rsp_word.seconds));
               compare_field("hundredths", 32'(expected_word.hundredths),
                             32'(rsp_word.hundredths));
               compare_field("countdown_done", 32'(expected_word.countdown_done),
                             32'(rsp_word.countdown_done));
               compare_field("last_lap_slot", 32'(expected_word.last_lap_slot),
                             32'(rsp_word.last_lap_slot));
               compare_field("running", 32'(expected_word.running), 32'(rsp_word.running));
            end
            results_seen++;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   function automatic req_word_type word_of(action_type a);
      logic [63:0]  raw;
      req_word_type w;
      raw = {$urandom, $urandom};
      w = raw[$bits(req_word_type)-1:0];
      w.action = a;
      return w;
   endfunction

   function automatic logic [7:0] pick_edge(int lim);
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'(lim - 1);
         2: return 8'(lim);
         3: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_act(action_type a);
      pending_words.push_back(word_of(a));
   endtask

   task automatic push_set(logic [7:0] h, logic [7:0] m, logic [7:0] s);
      req_word_type w;
      w = word_of(ACT_SET);
      w.set_hours   = h;
      w.set_minutes = m;
      w.set_seconds = s;
      pending_words.push_back(w);
   endtask

   task automatic push_adjust(logic [1:0] sel, bit down, bit fast);
      req_word_type w;
      w = word_of(ACT_ADJUST);
      w.field_select = sel;
      w.step_down    = down;
      w.fast         = fast;
      pending_words.push_back(w);
   endtask

   task automatic push_read(logic [7:0] slot);
      req_word_type w;
      w = word_of(ACT_READ);
      w.slot_number = slot;
      pending_words.push_back(w);
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_act(ACT_TICK);
   endtask

   task automatic random_mix(int count);
      int           made;
      int           r;
      int           n;
      req_word_type w;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            w = word_of(action_type'($urandom_range(0, 15)));
            pending_words.push_back(w);
            made++;
         end else if (r < 22) begin
            push_set(pick_edge(100), pick_edge(60), pick_edge(60));
            made++;
            if ($urandom_range(0, 1)) begin
               push_act(ACT_START);
               made++;
            end
         end else if (r < 32) begin
            push_adjust(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
            made++;
         end else if (r < 40) begin
            push_act(ACT_SAVE);
            made++;
         end else if (r < 48) begin
            push_read($urandom_range(0, 1) ? 8'($urandom_range(0, SLOTS - 1))
                                           : 8'($urandom_range(0, 255)));
            made++;
         end else if (r < 54) begin
            push_act(ACT_START);
            made++;
         end else if (r < 57) begin
            push_act(ACT_PAUSE);
            made++;
         end else if (r < 60) begin
            push_act(ACT_RESUME);
            made++;
         end else if (r < 62) begin
            push_act(ACT_CLEAR);
            made++;
         end else begin
            n = $urandom_range(1, 30);
            push_ticks(n);
            made += n;
         end
      end
   endtask

   task automatic wait_idle(int settle);
      while (pending_words.size() != 0 || req_valid || timer_results.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_COUNT_UP: count_up_reg = data[0];
         CSR_FAST_STEP: fast_step_reg = data;
         default: ;
      endcase
   endtask

   task automatic set_registers(logic [CSR_DATA_W-1:0] up, logic [CSR_DATA_W-1:0] step);
      wait_idle(SETTLE);
      write_csr(CSR_COUNT_UP, up);
      write_csr(CSR_FAST_STEP, step);
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, countdown with a fast step of five
      push_act(ACT_TICK);
      push_act(ACT_START);
      push_ticks(2);
      push_set(8'd255, 8'd255, 8'd255);
      push_set(8'd99, 8'd59, 8'd59);
      push_adjust(SEL_HOURS, 1'b0, 1'b0);
      push_adjust(SEL_MINUTES, 1'b0, 1'b1);
      push_adjust(SEL_SECONDS, 1'b1, 1'b1);
      push_adjust(SEL_SECONDS, 1'b1, 1'b0);
      push_adjust(SEL_HOURS, 1'b1, 1'b1);
      push_adjust(SEL_MINUTES, 1'b1, 1'b0);
      push_adjust(SEL_NONE, 1'b1, 1'b1);
      push_act(ACT_START);
      push_act(ACT_TICK);
      push_act(ACT_PAUSE);
      push_act(ACT_TICK);
      push_act(ACT_RESUME);
      push_act(ACT_TICK);
      push_act(ACT_SAVE);
      push_act(ACT_SAVE);
      push_read(8'd1);
      push_read(8'd0);
      push_read(8'(SLOTS));
      push_read(8'd255);
      push_act(ACT_SPARE_LO);
      push_act(ACT_SPARE_HI);
      push_act(ACT_CLEAR);

      // count up through the 99:59:59 wrap
      set_registers(6'd1, 6'd59);
      push_set(8'd99, 8'd59, 8'd59);
      push_act(ACT_START);
      push_ticks(TICKS + 3);
      random_mix(30);

      // count down one second to expiry, no idling on either side
      set_registers(6'd0, 6'd1);
      steady = 1'b1;
      push_set(8'd0, 8'd0, 8'd1);
      push_act(ACT_START);
      push_ticks(TICKS + 3);
      random_mix(30);
      wait_idle(0);
      steady = 1'b0;

      set_registers(6'h3F, 6'd63);
      random_mix(30);

      set_registers(6'h3E, 6'd0);
      random_mix(30);

      set_registers(6'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      random_mix(30);

      wait_idle(SETTLE);
      $display("covered %0d words: %0d ticks, %0d countdown expiries, %0d lap saves, %0d reads",
               words_sent, ticks_sent, expiries, laps_saved, slot_reads);
      $display("%0d register settings, %0d results checked, %0d mismatches",
               settings, results_seen, mismatches);
      if (mismatches == 0) begin
         $display("stopwatch_countdown_lap_timer_tb: PASS");
      end else begin
         $display("stopwatch_countdown_lap_timer_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d words still pending, %0d results outstanding",
               pending_words.size(), timer_results.size());
      $display("stopwatch_countdown_lap_timer_tb: FAIL");
      $finish;
   end

endmodule
